// ----- hdl/tdw_pkg.sv -----
// Shared constants, types and tables for the diffusion-weighted signal block.
package tdw_pkg;

  localparam int MAX_GRADIENTS = 63;
  localparam int TERMS         = 6;
  localparam int TBL_DEPTH     = MAX_GRADIENTS * TERMS;
  localparam int TBL_AW        = $clog2(TBL_DEPTH);
  localparam int SLOT_W        = 6;
  localparam int DATA_W        = 32;
  localparam int CFG_W         = 6;
  localparam int MUL_W         = 34;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int NUM_W         = 64;
  localparam int DEN_W         = 43;
  localparam int ACC_W         = 52;
  localparam int LN_W          = 37;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_VOXEL = 1'b1;

  localparam logic REG_GRAD_COUNT = 1'b0;
  localparam logic REG_SCALE      = 1'b1;

  localparam logic [30:0]       ONE_Q30   = 31'h4000_0000;
  localparam logic [LN_W-1:0]   LN2_Q30   = 37'd744261118;
  localparam int                LN_OFFSET = 66;
  localparam logic [LN_W:0]     LN_BIAS   = 38'(LN_OFFSET) * 38'd744261118;
  localparam logic signed [31:0] T_MAX    = 32'sd385875968;
  localparam logic signed [31:0] T_MIN    = -32'sd754974720;
  localparam logic [3:0]        HORNER_K  = 4'd12;
  localparam logic [9:0]        SCALE_K   = 10'd1000;

  typedef enum logic [4:0] {
    S_IDLE,
    L_SQ, L_CHK, L_ZERO, L_SQRT, L_SCALE, L_SCALE2, L_TERM, L_TDIV, L_TWAIT,
    V_RD, V_MUL, V_ACC, V_NEG, V_LN, V_EXP1, V_EXP2, V_EXP3, V_SCL, V_SHF, V_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // floor(2^32 / k) for the Horner divisors
  function automatic logic [32:0] recip(input logic [3:0] k);
    case (k)
      4'd1:    recip = 33'h1_0000_0000;
      4'd2:    recip = 33'd2147483648;
      4'd3:    recip = 33'd1431655765;
      4'd4:    recip = 33'd1073741824;
      4'd5:    recip = 33'd858993459;
      4'd6:    recip = 33'd715827882;
      4'd7:    recip = 33'd613566756;
      4'd8:    recip = 33'd536870912;
      4'd9:    recip = 33'd477218588;
      4'd10:   recip = 33'd429496729;
      4'd11:   recip = 33'd390451572;
      4'd12:   recip = 33'd357913941;
      default: recip = '0;
    endcase
  endfunction

endpackage

// ----- hdl/tensor_to_diffusion_weighted_signal.sv -----
// Top level: gradient table load and per-voxel diffusion-weighted signal synthesis.
//
// Channel   Dir  Handshake              Payload
// cfg       in   cfg_write              cfg_index, cfg_data
// in        in   in_valid / in_ready    kind, gradient_slot, grad_*, base_intensity, tensor_*
// out       out  out_valid / out_ready  image_index, weighted_intensity, last_of_voxel
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Load item: 4 squaring steps, the 32-step square root, 6 divisions of 64 steps each; a zero
// gradient writes zeros instead, and a load to slot 63 is accepted but leaves the table as is.
// Voxel item: image 0 (the base intensity) first, then for each gradient image 6 table reads
// and products, ln2 range reduction, 12 Horner steps on the shared multiplier, final scale.
// All products but the small q0 * k check of the Horner divide share one 34x34 multiplier.
// A stalled output holds the sequencer in its emit state; nothing is dropped.
// Synchronous reset initialises sequencer and control registers; the table starts undefined.
module tensor_to_diffusion_weighted_signal (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [tdw_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             kind,
  input  logic [tdw_pkg::SLOT_W-1:0]       gradient_slot,
  input  logic signed [31:0]               grad_x,
  input  logic signed [31:0]               grad_y,
  input  logic signed [31:0]               grad_z,
  input  logic [31:0]                      base_intensity,
  input  logic signed [31:0]               tensor_xx,
  input  logic signed [31:0]               tensor_xy,
  input  logic signed [31:0]               tensor_yy,
  input  logic signed [31:0]               tensor_xz,
  input  logic signed [31:0]               tensor_yz,
  input  logic signed [31:0]               tensor_zz,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [5:0]                       image_index,
  output logic [31:0]                      weighted_intensity,
  output logic                             last_of_voxel
);
  import tdw_pkg::*;

  state_t state, state_next;

  // configuration
  logic [5:0] grad_count;
  logic       scale;

  // load datapath
  logic signed [31:0] gx, gy, gz;
  logic [TBL_AW-1:0]  slot_base;
  logic [63:0]        sum;
  logic [63:0]        sq_rem, sq_res, sq_bit;
  logic [DEN_W-1:0]   den;
  logic [2:0]         term;
  logic [5:0]         cnt;
  logic               neg;

  // voxel datapath
  logic [31:0]              base;
  logic signed [31:0]       dt [TERMS];
  logic [5:0]               vcount, kidx;
  logic [TBL_AW-1:0]        rowbase;
  logic signed [ACC_W-1:0]  acc;
  logic [LN_W-1:0]          lnrem, lnd;
  logic [6:0]               lnq;
  logic [30:0]              eacc;
  logic [3:0]               hk;
  logic [30:0]              hv;
  logic [31:0]              pend_val;
  logic [5:0]               pend_idx;
  logic                     pend_last;

  // shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     ram_we;
  logic [TBL_AW-1:0]        ram_waddr, ram_raddr;
  logic [31:0]              ram_wdata, ram_rdata;
  div_req_t                 div_req;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;

  tdw_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  tdw_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quo(div_quo));

  tdw_ram #(.WIDTH(DATA_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  function automatic logic signed [MUL_W-1:0] sx(input logic signed [31:0] v);
    sx = {{(MUL_W-32){v[31]}}, v};
  endfunction

  // helper values
  logic               accept, emit_ok;
  logic [5:0]         vcnt_in;
  logic signed [31:0] pair_a, pair_b, gsq;
  logic signed [63:0] prod64;
  logic [63:0]        prod_u, mag, sq_try;
  logic               sq_ge, cross_term;
  logic signed [ACC_W-1:0] dot_sh, dot_add;
  logic signed [ACC_W:0]   tneg;
  logic signed [31:0]      tcl;
  logic signed [LN_W:0]    t30, tp;
  logic [30:0]        q0, hq;
  logic [34:0]        q0k, remk;
  logic [31:0]        div_sat;
  logic signed [7:0]  sh_s, sh_n;
  logic [1:0]         sh_l;
  logic [64:0]        sh_rnd, sh_r;
  logic [31:0]        scl_val;

  assign accept     = in_valid && in_ready;
  assign emit_ok    = !out_valid || out_ready;
  assign vcnt_in    = (grad_count > 6'(MAX_GRADIENTS)) ? 6'(MAX_GRADIENTS) : grad_count;
  assign prod64     = mul_p[63:0];
  assign prod_u     = mul_p[63:0];
  assign cross_term = (term == 3'd1) || (term == 3'd2) || (term == 3'd4);

  always_comb begin
    // weight term order: xx, xy, xz, yy, yz, zz
    case (term)
      3'd0, 3'd1, 3'd2: pair_a = gx;
      3'd3, 3'd4:       pair_a = gy;
      default:          pair_a = gz;
    endcase
    case (term)
      3'd0:       pair_b = gx;
      3'd1, 3'd3: pair_b = gy;
      default:    pair_b = gz;
    endcase
    case (cnt[1:0])
      2'd0:    gsq = gx;
      2'd1:    gsq = gy;
      default: gsq = gz;
    endcase

    mag    = prod64[63] ? 64'(-prod64) : 64'(prod64);
    sq_try = sq_res + sq_bit;
    sq_ge  = sq_rem >= sq_try;

    if (neg) begin
      div_sat = (div_quo >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-div_quo[31:0]);
    end else begin
      div_sat = (div_quo >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
    end

    // floor(w*D / 2^16), doubled for the off-diagonal terms
    dot_sh  = ACC_W'(prod64 >>> 16);
    dot_add = cross_term ? (dot_sh <<< 1) : dot_sh;

    // t = -x, clamped, then biased so the ln2 reduction works on a non-negative value
    tneg = -{acc[ACC_W-1], acc};
    if (tneg > (ACC_W+1)'(T_MAX)) begin
      tcl = T_MAX;
    end else if (tneg < (ACC_W+1)'(T_MIN)) begin
      tcl = T_MIN;
    end else begin
      tcl = 32'(tneg);
    end
    t30 = {tcl[LN_W-7], tcl[LN_W-7:0], 6'b0};
    tp  = t30 + $signed(LN_BIAS);

    // Horner divide by k: reciprocal estimate plus one correction
    q0   = mul_p[62:32];
    q0k  = 35'(q0) * 35'(hk);
    remk = 35'(hv) - q0k;
    hq   = q0 + 31'(remk >= 35'(hk));

    // scale by 2^n with n = lnq - LN_OFFSET, shift right by 30 - n
    sh_s    = 8'sd96 - $signed({1'b0, lnq});
    sh_n    = -sh_s;
    sh_l    = sh_n[1:0];
    sh_rnd  = '0;
    sh_r    = '0;
    if (sh_s <= 8'sd0) begin
      if (prod_u > (64'hFFFF_FFFF >> sh_l)) begin
        scl_val = '1;
      end else begin
        scl_val = 32'(prod_u << sh_l);
      end
    end else if (sh_s >= 8'sd64) begin
      scl_val = '0;
    end else begin
      sh_rnd  = {1'b0, prod_u} + (65'd1 << (sh_s[5:0] - 6'd1));
      sh_r    = sh_rnd >> sh_s[5:0];
      scl_val = (sh_r > 65'hFFFF_FFFF) ? '1 : sh_r[31:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    ram_we      = 1'b0;
    ram_waddr   = slot_base + TBL_AW'(term);
    ram_wdata   = '0;
    ram_raddr   = rowbase + TBL_AW'(term);
    div_req     = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (kind == KIND_VOXEL) begin
            state_next = V_EMIT;
          end else if (gradient_slot < SLOT_W'(MAX_GRADIENTS)) begin
            state_next = L_SQ;
          end
        end
      end
      L_SQ: begin
        mul_a = sx(gsq);
        mul_b = sx(gsq);
        if (cnt == 6'd3) state_next = L_CHK;
      end
      L_CHK: state_next = (sum == '0) ? L_ZERO : L_SQRT;
      L_ZERO: begin
        ram_we = 1'b1;
        if (term == 3'(TERMS - 1)) state_next = S_IDLE;
      end
      L_SQRT: if (cnt == 6'd31) state_next = L_SCALE;
      L_SCALE: begin
        mul_a = {2'b0, sq_res[31:0]};
        mul_b = MUL_W'(SCALE_K);
        state_next = L_SCALE2;
      end
      L_SCALE2: state_next = L_TERM;
      L_TERM: begin
        mul_a = sx(pair_a);
        mul_b = sx(pair_b);
        state_next = L_TDIV;
      end
      L_TDIV: begin
        div_req.start = 1'b1;
        div_req.num   = mag + 64'(den >> 1);
        div_req.den   = den;
        state_next    = L_TWAIT;
      end
      L_TWAIT: begin
        if (div_done) begin
          ram_we    = 1'b1;
          ram_wdata = div_sat;
          state_next = (term == 3'(TERMS - 1)) ? S_IDLE : L_TERM;
        end
      end
      V_RD: state_next = V_MUL;
      V_MUL: begin
        mul_a = sx($signed(ram_rdata));
        mul_b = sx(dt[term]);
        state_next = V_ACC;
      end
      V_ACC: state_next = (term == 3'(TERMS - 1)) ? V_NEG : V_RD;
      V_NEG: state_next = V_LN;
      V_LN: if (cnt == 6'd6) state_next = V_EXP1;
      V_EXP1: begin
        mul_a = {3'b0, eacc};
        mul_b = {4'b0, lnrem[29:0]};
        state_next = V_EXP2;
      end
      V_EXP2: begin
        mul_a = {3'b0, mul_p[60:30]};
        mul_b = {1'b0, recip(hk)};
        state_next = V_EXP3;
      end
      V_EXP3: state_next = (hk == 4'd1) ? V_SCL : V_EXP1;
      V_SCL: begin
        mul_a = {2'b0, base};
        mul_b = {3'b0, eacc};
        state_next = V_SHF;
      end
      V_SHF: state_next = V_EMIT;
      V_EMIT: begin
        if (emit_ok) begin
          state_next = pend_last ? S_IDLE : V_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration and output control
  always_ff @(posedge clk) begin
    if (rst) begin
      grad_count <= 6'd6;
      scale      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GRAD_COUNT: grad_count <= cfg_data;
          REG_SCALE:      scale      <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == V_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          gx        <= grad_x;
          gy        <= grad_y;
          gz        <= grad_z;
          slot_base <= (TBL_AW'(gradient_slot) << 2) + (TBL_AW'(gradient_slot) << 1);
          sum       <= '0;
          cnt       <= '0;
          base      <= base_intensity;
          dt[0]     <= tensor_xx;
          dt[1]     <= tensor_xy;
          dt[2]     <= tensor_xz;
          dt[3]     <= tensor_yy;
          dt[4]     <= tensor_yz;
          dt[5]     <= tensor_zz;
          vcount    <= vcnt_in;
          pend_idx  <= '0;
          pend_val  <= base_intensity;
          pend_last <= (vcnt_in == '0);
          kidx      <= 6'd1;
          rowbase   <= '0;
          acc       <= '0;
          term      <= '0;
        end
      end
      L_SQ: begin
        cnt <= cnt + 6'd1;
        if (cnt != '0) sum <= sum + prod_u;
      end
      L_CHK: begin
        sq_rem <= sum;
        sq_res <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
        cnt    <= '0;
        term   <= '0;
      end
      L_ZERO: term <= term + 3'd1;
      L_SQRT: begin
        cnt <= cnt + 6'd1;
        if (sq_ge) begin
          sq_rem <= sq_rem - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      L_SCALE2: begin
        den  <= scale ? mul_p[DEN_W-1:0] : DEN_W'(sq_res[31:0]);
        term <= '0;
      end
      L_TDIV: neg <= prod64[63];
      L_TWAIT: if (div_done) term <= term + 3'd1;
      V_ACC: begin
        acc  <= acc + dot_add;
        term <= term + 3'd1;
      end
      V_NEG: begin
        lnrem <= tp[LN_W-1:0];
        lnd   <= LN2_Q30 << 6;
        lnq   <= '0;
        cnt   <= '0;
        eacc  <= ONE_Q30;
        hk    <= HORNER_K;
      end
      V_LN: begin
        cnt <= cnt + 6'd1;
        lnd <= lnd >> 1;
        if (lnrem >= lnd) begin
          lnrem <= lnrem - lnd;
          lnq   <= {lnq[5:0], 1'b1};
        end else begin
          lnq   <= {lnq[5:0], 1'b0};
        end
      end
      V_EXP2: hv <= mul_p[60:30];
      V_EXP3: begin
        eacc <= ONE_Q30 + hq;
        hk   <= hk - 4'd1;
      end
      V_SHF: begin
        pend_val  <= scl_val;
        pend_idx  <= kidx;
        pend_last <= (kidx == vcount);
      end
      V_EMIT: begin
        if (emit_ok) begin
          image_index        <= pend_idx;
          weighted_intensity <= pend_val;
          last_of_voxel      <= pend_last;
          if (pend_idx != '0) begin
            kidx    <= kidx + 6'd1;
            rowbase <= rowbase + TBL_AW'(TERMS);
          end
          acc  <= '0;
          term <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/tdw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tdw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/tdw_mul.sv -----
// Shared signed multiplier, product registered.
module tdw_mul (
  input  logic                              clk,
  input  logic signed [tdw_pkg::MUL_W-1:0]  a,
  input  logic signed [tdw_pkg::MUL_W-1:0]  b,
  output logic signed [tdw_pkg::PROD_W-1:0] p
);
  import tdw_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- hdl/tdw_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tdw_div (
  input  logic                       clk,
  input  logic                       rst,
  input  tdw_pkg::div_req_t          req,
  output logic                       done,
  output logic [tdw_pkg::NUM_W-1:0]  quo
);
  import tdw_pkg::*;

  logic             run;
  logic [5:0]       cnt;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        run  <= 1'b1;
        done <= 1'b0;
      end else if (run && cnt == 6'd63) begin
        run  <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      den <= req.den;
      rem <= '0;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 6'd1;
      if (fits) begin
        rem <= DEN_W'(rem_sh - {1'b0, den});
      end else begin
        rem <= rem_sh[DEN_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule
